FILE: src/ptrcur_pkg.sv
`timescale 1ns / 1ps
// shared types and constants for the pointer cursor tracker
// no dependencies; imported by every module of the block
package ptrcur_pkg;

  // fixed field widths of the stream items and config registers
  localparam int OP_W       = 2;
  localparam int DELTA_W    = 10;
  localparam int SENS_W     = 4;
  localparam int SCREEN_W   = 13;
  localparam int CURSOR_W   = 12;
  localparam int CFG_IDX_W  = 2;
  localparam int IN_DATA_W  = 24;
  localparam int OUT_DATA_W = 32;

  // reset values
  localparam int RESET_X_PX = 400;
  localparam int RESET_Y_PX = 300;
  localparam logic [SENS_W-1:0]   RESET_SENS   = SENS_W'(3);
  localparam logic [SCREEN_W-1:0] RESET_WIDTH  = SCREEN_W'(800);
  localparam logic [SCREEN_W-1:0] RESET_HEIGHT = SCREEN_W'(600);

  // config register indexes
  localparam logic [CFG_IDX_W-1:0] REG_SENSITIVITY   = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_SCREEN_WIDTH  = CFG_IDX_W'(1);
  localparam logic [CFG_IDX_W-1:0] REG_SCREEN_HEIGHT = CFG_IDX_W'(2);

  // item kinds carried on tuser
  typedef enum logic [OP_W-1:0] {
    OP_MOVE   = 2'd0,
    OP_BUTTON = 2'd1,
    OP_TICK   = 2'd2
  } op_t;

  // input tdata layout, lowest field last
  typedef struct packed {
    logic [IN_DATA_W-DELTA_W-DELTA_W-2:0] pad;
    logic                                 left_button;
    logic signed [DELTA_W-1:0]            delta_y;
    logic signed [DELTA_W-1:0]            delta_x;
  } in_item_t;

  // output tdata layout, lowest field last
  typedef struct packed {
    logic [OUT_DATA_W-CURSOR_W-CURSOR_W-2:0] pad;
    logic                                    button_held;
    logic [CURSOR_W-1:0]                     cursor_y;
    logic [CURSOR_W-1:0]                     cursor_x;
  } out_item_t;

endpackage

FILE: src/pointer_cursor_tracker_unit.sv
`timescale 1ns / 1ps
// top level of the pointer cursor tracker: stream ports, config registers, state
// depends on ptrcur_pkg, ptrcur_axis_move and ptrcur_smooth
//
// Tracks a pointer cursor from a stream of move events, button events and frame
// ticks (kind on s_tuser). Each transfer in gives exactly one transfer out with
// the integer cursor position and the latched button flag as they stand after
// that item. The block takes one item per clock cycle with no bubbles while
// m_tready is high; an item waits in the input register, where the move and
// smoothing logic updates the tracked state, and its result then leaves from
// the output register. The rate is set by the state loop: target, smoothed
// position and held flag are read and rewritten in the same cycle for each
// item. The input register keeps taking items while a result waits in the
// output register, and stalls only when both are full. Config registers may
// be written at any time the block is idle; a write to an unused index is
// dropped.
module pointer_cursor_tracker_unit #(
  parameter int COORD_BITS = 12,
  parameter int FRAC_BITS  = 16
) (
  input  logic                                clk,
  input  logic                                rst,
  // input stream
  input  logic                                s_tvalid,
  output logic                                s_tready,
  // delta_x [9:0], delta_y [19:10], left_button [20], zero pad [23:21]
  input  logic [ptrcur_pkg::IN_DATA_W-1:0]    s_tdata,
  // op [1:0]
  input  logic [ptrcur_pkg::OP_W-1:0]         s_tuser,
  // result stream
  output logic                                m_tvalid,
  input  logic                                m_tready,
  // cursor_x [11:0], cursor_y [23:12], button_held [24], zero pad [31:25]
  output logic [ptrcur_pkg::OUT_DATA_W-1:0]   m_tdata,
  // config write port
  input  logic                                cfg_we,
  input  logic [ptrcur_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [ptrcur_pkg::SCREEN_W-1:0]     cfg_data
);
  import ptrcur_pkg::*;

  localparam int POS_W         = COORD_BITS + FRAC_BITS;
  localparam int CoordMaxInt   = (1 << COORD_BITS) - 1;
  // reset position, saturated to the coordinate range
  localparam logic [COORD_BITS-1:0] RESET_X =
    COORD_BITS'((RESET_X_PX > CoordMaxInt) ? CoordMaxInt : RESET_X_PX);
  localparam logic [COORD_BITS-1:0] RESET_Y =
    COORD_BITS'((RESET_Y_PX > CoordMaxInt) ? CoordMaxInt : RESET_Y_PX);

  // config registers
  logic [SENS_W-1:0]   sensitivity;
  logic [SCREEN_W-1:0] screen_width;
  logic [SCREEN_W-1:0] screen_height;

  // tracked state
  logic [COORD_BITS-1:0] target_x, target_x_next;
  logic [COORD_BITS-1:0] target_y, target_y_next;
  logic [POS_W-1:0]      current_x, current_x_next;
  logic [POS_W-1:0]      current_y, current_y_next;
  logic                  held, held_next;

  // input register
  logic     in_valid;
  op_t      in_op;
  in_item_t in_item;

  // output register
  logic      out_valid;
  out_item_t out_item;

  // unit results
  logic [COORD_BITS-1:0] move_x, move_y;
  logic [POS_W-1:0]      smooth_x, smooth_y;

  logic fire;

  // item in the input register is processed when the output slot is free
  // or being emptied in the same cycle
  assign fire     = in_valid && (!out_valid || m_tready);
  assign s_tready = !in_valid || fire;
  assign m_tvalid = out_valid;
  assign m_tdata  = out_item;

  // config writes
  always_ff @(posedge clk) begin
    if (rst) begin
      sensitivity   <= RESET_SENS;
      screen_width  <= RESET_WIDTH;
      screen_height <= RESET_HEIGHT;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_SENSITIVITY:   sensitivity   <= cfg_data[SENS_W-1:0];
        REG_SCREEN_WIDTH:  screen_width  <= cfg_data;
        REG_SCREEN_HEIGHT: screen_height <= cfg_data;
        default: ;
      endcase
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_op   <= op_t'(s_tuser);
      in_item <= in_item_t'(s_tdata);
    end
  end

  ptrcur_axis_move #(
    .COORD_BITS(COORD_BITS)
  ) u_move_x (
    .target     (target_x),
    .delta      (in_item.delta_x),
    .sens       (sensitivity),
    .screen     (screen_width),
    .target_next(move_x)
  );

  ptrcur_axis_move #(
    .COORD_BITS(COORD_BITS)
  ) u_move_y (
    .target     (target_y),
    .delta      (in_item.delta_y),
    .sens       (sensitivity),
    .screen     (screen_height),
    .target_next(move_y)
  );

  ptrcur_smooth #(
    .COORD_BITS(COORD_BITS),
    .FRAC_BITS (FRAC_BITS)
  ) u_smooth (
    .held          (held),
    .target_x      (target_x),
    .target_y      (target_y),
    .current_x     (current_x),
    .current_y     (current_y),
    .current_x_next(smooth_x),
    .current_y_next(smooth_y)
  );

  // next state per item kind; unused kind leaves everything as it is
  always_comb begin
    target_x_next  = target_x;
    target_y_next  = target_y;
    current_x_next = current_x;
    current_y_next = current_y;
    held_next      = held;
    case (in_op)
      OP_MOVE: begin
        target_x_next = move_x;
        target_y_next = move_y;
        // a move only ever latches the button, never releases it
        if (in_item.left_button) begin
          held_next = 1'b1;
        end
      end
      OP_BUTTON: begin
        held_next = in_item.left_button;
      end
      OP_TICK: begin
        current_x_next = smooth_x;
        current_y_next = smooth_y;
      end
      default: ;
    endcase
  end

  // tracked state
  always_ff @(posedge clk) begin
    if (rst) begin
      target_x  <= RESET_X;
      target_y  <= RESET_Y;
      current_x <= {RESET_X, {FRAC_BITS{1'b0}}};
      current_y <= {RESET_Y, {FRAC_BITS{1'b0}}};
      held      <= 1'b0;
    end else if (fire) begin
      target_x  <= target_x_next;
      target_y  <= target_y_next;
      current_x <= current_x_next;
      current_y <= current_y_next;
      held      <= held_next;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (fire) begin
      out_valid <= 1'b1;
    end else if (m_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      out_item.pad         <= '0;
      out_item.button_held <= held_next;
      out_item.cursor_x    <= CURSOR_W'(current_x_next[POS_W-1:FRAC_BITS]);
      out_item.cursor_y    <= CURSOR_W'(current_y_next[POS_W-1:FRAC_BITS]);
    end
  end

endmodule

FILE: src/ptrcur_axis_move.sv
`timescale 1ns / 1ps
// one axis of a move event: scale the delta, add to the target, clamp to the screen
// depends on ptrcur_pkg
module ptrcur_axis_move #(
  parameter int COORD_BITS = 12
) (
  input  logic [COORD_BITS-1:0]                 target,
  input  logic signed [ptrcur_pkg::DELTA_W-1:0] delta,
  input  logic [ptrcur_pkg::SENS_W-1:0]         sens,
  input  logic [ptrcur_pkg::SCREEN_W-1:0]       screen,
  output logic [COORD_BITS-1:0]                 target_next
);
  import ptrcur_pkg::*;

  // room for the largest target plus the largest scaled delta, with sign
  localparam int SUM_W = ((COORD_BITS > 14) ? COORD_BITS : 14) + 2;
  localparam logic [COORD_BITS-1:0] COORD_MAX = '1;

  logic signed [DELTA_W+SENS_W:0] scaled;
  logic [SUM_W-1:0]               target_ext;
  logic signed [SUM_W-1:0]        sum;
  logic [SCREEN_W-1:0]            screen_m1;
  logic [COORD_BITS-1:0]          hi;

  always_comb begin
    scaled     = delta * $signed({1'b0, sens});
    target_ext = SUM_W'(target);
    sum        = $signed(target_ext) + SUM_W'(scaled);
    screen_m1  = screen - SCREEN_W'(1);

    // largest position on this axis
    if (screen == '0) begin
      hi = '0;
    end else if (SUM_W'(screen_m1) > SUM_W'(COORD_MAX)) begin
      hi = COORD_MAX;
    end else begin
      hi = COORD_BITS'(screen_m1);
    end

    if (sum < 0) begin
      target_next = '0;
    end else if (sum > $signed(SUM_W'(hi))) begin
      target_next = hi;
    end else begin
      target_next = COORD_BITS'(sum);
    end
  end

endmodule

FILE: src/ptrcur_smooth.sv
`timescale 1ns / 1ps
// frame tick smoothing of the fixed point cursor toward the target
// depends on ptrcur_pkg
module ptrcur_smooth #(
  parameter int COORD_BITS = 12,
  parameter int FRAC_BITS  = 16
) (
  input  logic                          held,
  input  logic [COORD_BITS-1:0]         target_x,
  input  logic [COORD_BITS-1:0]         target_y,
  input  logic [COORD_BITS+FRAC_BITS-1:0] current_x,
  input  logic [COORD_BITS+FRAC_BITS-1:0] current_y,
  output logic [COORD_BITS+FRAC_BITS-1:0] current_x_next,
  output logic [COORD_BITS+FRAC_BITS-1:0] current_y_next
);
  import ptrcur_pkg::*;

  localparam int POS_W = COORD_BITS + FRAC_BITS;
  localparam int GAP_W = POS_W + 1;
  localparam logic signed [GAP_W-1:0] ONE  = GAP_W'(64'd1 << FRAC_BITS);
  localparam logic signed [GAP_W-1:0] TAIL = GAP_W'(64'd1 << (FRAC_BITS - 2));

  logic [POS_W-1:0]        target_fx_x, target_fx_y;
  logic signed [GAP_W-1:0] gap_x, gap_y;
  logic signed [GAP_W-1:0] step_x, step_y;
  logic                    far, near_x, near_y;

  always_comb begin
    target_fx_x = {target_x, {FRAC_BITS{1'b0}}};
    target_fx_y = {target_y, {FRAC_BITS{1'b0}}};
    gap_x = $signed({1'b0, target_fx_x}) - $signed({1'b0, current_x});
    gap_y = $signed({1'b0, target_fx_y}) - $signed({1'b0, current_y});

    // held button or a jump of over one pixel snaps both axes
    far = held || gap_x > ONE || gap_x < -ONE || gap_y > ONE || gap_y < -ONE;
    near_x = gap_x > -TAIL && gap_x < TAIL;
    near_y = gap_y > -TAIL && gap_y < TAIL;

    // half the gap, rounded toward minus infinity
    step_x = $signed({1'b0, current_x}) + (gap_x >>> 1);
    step_y = $signed({1'b0, current_y}) + (gap_y >>> 1);

    current_x_next = (far || near_x) ? target_fx_x : POS_W'(step_x);
    current_y_next = (far || near_y) ? target_fx_y : POS_W'(step_y);
  end

endmodule
